>>> rtl/core/slm_pkg.sv
// Shared types and constants for the sorted list merge block.
package slm_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int TOT_W = CNT_W + 1;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

	localparam logic [1:0] FUNC_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] FUNC_MERGE      = 2'd2;

	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] payload;
	} rec_t;

endpackage

>>> rtl/core/sorted_list_merge.sv
// Two-way merge of two offset-sorted record lists held in two RAMs.
//
//  channel  dir  handshake           payload
//  input    in   in_valid/in_stall   func, match_offset, match_payload
//  output   out  out_valid/out_stall out_offset, out_payload, from_right,
//                                    last_record, overflowed
//
// A load is accepted whenever no merge is running.
// A merge primes both RAM read ports in its own transfer cycle, then emits one
// record per cycle unless stalled; the taken side's RAM reads its next record.
// A merge holds off the input until its last record has been emitted.
// Reset clears counts, overflow flag and control; RAM contents are not cleared.
// A stall on the output holds the output register and pauses the merge.
module sorted_list_merge
	import slm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] match_offset,
	input  logic [31:0] match_payload,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_offset,
	output logic [31:0] out_payload,
	output logic        from_right,
	output logic        last_record,
	output logic        overflowed
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_MERGE = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] lcnt_q, rcnt_q;
	logic             flag_q;
	logic [CNT_W-1:0] ltot_q, rtot_q;
	logic [CNT_W-1:0] li_q, ri_q;
	logic [TOT_W-1:0] total_q;
	logic             flag_snap_q;
	logic             out_valid_q;
	rec_t             out_rec_q;
	logic             from_right_q, last_q, ovf_q;

	logic             accept, load_l, load_r, start;
	logic             l_we, r_we, l_re, r_re;
	logic [IDX_W-1:0] l_raddr, r_raddr;
	logic [CNT_W-1:0] li_inc, ri_inc;
	rec_t             wrec, l_head, r_head;
	logic             left_ok, right_ok, take_left, emit, emit_last;
	logic [TOT_W-1:0] pos;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load_l   = accept && (func == FUNC_LOAD_LEFT);
	assign load_r   = accept && (func == FUNC_LOAD_RIGHT);
	assign start    = accept && (func == FUNC_MERGE);

	assign wrec = '{offset: match_offset, payload: match_payload};
	// drop a load into a full store
	assign l_we = load_l && (lcnt_q < DEPTH_CNT);
	assign r_we = load_r && (rcnt_q < DEPTH_CNT);

	assign left_ok   = (li_q < ltot_q);
	assign right_ok  = (ri_q < rtot_q);
	assign take_left = left_ok && (!right_ok || (l_head.offset < r_head.offset));
	assign emit      = (state_q == ST_MERGE) && (!out_valid_q || !out_stall);
	assign pos       = TOT_W'(li_q) + TOT_W'(ri_q);
	assign emit_last = emit && ((pos + TOT_W'(1)) == total_q);

	assign li_inc = li_q + CNT_W'(1);
	assign ri_inc = ri_q + CNT_W'(1);

	// prime both heads at merge start, then refetch the consumed side
	always_comb begin
		l_re    = start || (emit && take_left);
		r_re    = start || (emit && !take_left);
		l_raddr = start ? '0 : li_inc[IDX_W-1:0];
		r_raddr = start ? '0 : ri_inc[IDX_W-1:0];
	end

	slm_ram #(.WIDTH($bits(rec_t)), .DEPTH(LIST_DEPTH)) u_left_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (lcnt_q[IDX_W-1:0]),
		.wdata (wrec),
		.re    (l_re),
		.raddr (l_raddr),
		.rdata (l_head)
	);

	slm_ram #(.WIDTH($bits(rec_t)), .DEPTH(LIST_DEPTH)) u_right_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (rcnt_q[IDX_W-1:0]),
		.wdata (wrec),
		.re    (r_re),
		.raddr (r_raddr),
		.rdata (r_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lcnt_q      <= '0;
			rcnt_q      <= '0;
			flag_q      <= 1'b0;
			ltot_q      <= '0;
			rtot_q      <= '0;
			li_q        <= '0;
			ri_q        <= '0;
			total_q     <= '0;
			flag_snap_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (l_we) begin
				lcnt_q <= lcnt_q + CNT_W'(1);
			end
			if (r_we) begin
				rcnt_q <= rcnt_q + CNT_W'(1);
			end
			if ((load_l && !l_we) || (load_r && !r_we)) begin
				flag_q <= 1'b1;
			end
			if (start) begin
				// snapshot the run, then empty the stores
				ltot_q      <= lcnt_q;
				rtot_q      <= rcnt_q;
				li_q        <= '0;
				ri_q        <= '0;
				total_q     <= TOT_W'(lcnt_q) + TOT_W'(rcnt_q);
				flag_snap_q <= flag_q;
				lcnt_q      <= '0;
				rcnt_q      <= '0;
				flag_q      <= 1'b0;
				if ((lcnt_q != '0) || (rcnt_q != '0)) begin
					state_q <= ST_MERGE;
				end
			end
			if (emit) begin
				if (take_left) begin
					li_q <= li_inc;
				end else begin
					ri_q <= ri_inc;
				end
				if (emit_last) begin
					state_q <= ST_IDLE;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_rec_q    <= take_left ? l_head : r_head;
			from_right_q <= !take_left;
			last_q       <= emit_last;
			ovf_q        <= flag_snap_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_offset  = out_rec_q.offset;
	assign out_payload = out_rec_q.payload;
	assign from_right  = from_right_q;
	assign last_record = last_q;
	assign overflowed  = ovf_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(lcnt_q <= DEPTH_CNT) && (rcnt_q <= DEPTH_CNT))
		else $error("store count beyond depth");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> ((li_q <= ltot_q) && (ri_q <= rtot_q)))
		else $error("merge index past list end");

	a_head_avail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (left_ok || right_ok))
		else $error("merge running with both lists drained");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_last |=> (state_q == ST_IDLE))
		else $error("merge did not end after last record");

	a_last_drained: assert property (@(posedge clk) disable iff (!arst_n)
		emit_last |=> ((li_q == ltot_q) && (ri_q == rtot_q)))
		else $error("last record flagged with records left");

endmodule

>>> rtl/core/slm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
